### hw/rtl/tlpte_pkg.sv
`default_nettype none

package tlpte_pkg;

  // Table pool and address split
  localparam int TABLE_SLOTS = 16;
  localparam int DIR_ENTRIES = 1024;
  localparam int TBL_ENTRIES = 1024;
  localparam int IDX_W       = 10;
  localparam int OFF_W       = 12;
  localparam int FRAME_W     = 20;
  localparam int FLAG_W      = 12;
  localparam int ADDR_W      = 32;
  localparam int DIR_SHIFT   = 22;
  localparam int PAGE_SHIFT  = 12;

  localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int NF_W      = $clog2(TABLE_SLOTS + 1);
  localparam int TBL_DEPTH = TABLE_SLOTS * TBL_ENTRIES;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int DIR_AW    = $clog2(DIR_ENTRIES);

  // Directory word {present, slot}; table word {frame, present}
  localparam int DIR_W = 1 + SLOT_W;
  localparam int TBL_W = FRAME_W + 1;

  // Opcodes
  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_XLATE = 2'd1;
  localparam logic [1:0] OP_UNMAP = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMAP  = 2'd1;
  localparam logic [1:0] ST_NOSLOT = 2'd2;

  // Reset value of the directory flags register, present bit only
  localparam logic NEW_DIR_PRESENT_RST = 1'b1;

  typedef struct packed {
    logic clr;     // clearing sweep step
    logic accept;  // capture an input transfer, read directory
    logic walk;    // directory data valid, read table
    logic wb;      // table data valid, write back and present result
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/two_level_page_table_engine_core.sv
`default_nettype none

// Steps: the accept cycle with the directory read, the dependent table read,
// then the write-back. out_valid is registered and high in the write-back cycle,
// which is when the result transfer comes. busy is low only when idle, so a new
// item is taken only after the last one is written back.
// Reset: a clearing sweep over every table address zeroes both memories; busy
// stays high until it ends. The receiver cannot stall results.
module two_level_page_table_engine_core
  import tlpte_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [ADDR_W-1:0] in_virt_addr,
  input  wire logic [ADDR_W-1:0] in_phys_addr,
  input  wire logic [FLAG_W-1:0] in_entry_flags,
  input  wire logic              cfg_wr_en,
  input  wire logic [FLAG_W-1:0] cfg_wr_data,
  output logic                   out_valid,
  output logic      [ADDR_W-1:0] out_phys_out,
  output logic                   out_freed_valid,
  output logic      [ADDR_W-1:0] out_freed_frame,
  output logic      [1:0]        out_status
);

  cmd_t cmd;
  sts_t sts;

  tlpte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tlpte_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_virt_addr    (in_virt_addr),
    .in_phys_addr    (in_phys_addr),
    .in_entry_flags  (in_entry_flags),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_phys_out    (out_phys_out),
    .out_freed_valid (out_freed_valid),
    .out_freed_frame (out_freed_frame),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

### hw/rtl/tlpte_ram.sv
`default_nettype none

module tlpte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/tlpte_ctrl.sv
`default_nettype none

module tlpte_ctrl
  import tlpte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_WB
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r;

  // Sequence: clear after reset, then idle -> walk -> write back
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_WALK;
      S_WALK:  state_nxt = S_WB;
      S_WB:    state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= (state_nxt == S_WB);
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd.clr    = (state_r == S_CLEAR);
    cmd.accept = (state_r == S_IDLE) && start;
    cmd.walk   = (state_r == S_WALK);
    cmd.wb     = (state_r == S_WB);
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hw/rtl/tlpte_dp.sv
`default_nettype none

module tlpte_dp
  import tlpte_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [ADDR_W-1:0] in_virt_addr,
  input  wire logic [ADDR_W-1:0] in_phys_addr,
  input  wire logic [FLAG_W-1:0] in_entry_flags,
  input  wire logic              cfg_wr_en,
  input  wire logic [FLAG_W-1:0] cfg_wr_data,
  output logic      [ADDR_W-1:0] out_phys_out,
  output logic                   out_freed_valid,
  output logic      [ADDR_W-1:0] out_freed_frame,
  output logic      [1:0]        out_status
);

  // Configuration: only the present bit of the new directory flags matters
  logic new_dir_present_r;

  // Clearing sweep
  logic [TBL_AW-1:0] clr_ctr_r;

  // Captured item
  logic [1:0]         op_r;
  logic [IDX_W-1:0]   di_r;
  logic [IDX_W-1:0]   ti_r;
  logic [OFF_W-1:0]   off_r;
  logic [FRAME_W-1:0] frame_in_r;
  logic               present_in_r;

  // Walk results
  logic              hit_r;
  logic              alloc_r;
  logic              full_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TBL_AW-1:0] tbl_addr_r;

  // Slot allocator
  logic [NF_W-1:0] next_free_r;

  // Memory ports
  logic              dir_we;
  logic [DIR_AW-1:0] dir_waddr;
  logic [DIR_W-1:0]  dir_wdata;
  logic [DIR_AW-1:0] dir_raddr;
  logic [DIR_W-1:0]  dir_rdata;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [TBL_W-1:0]  tbl_wdata;
  logic [TBL_AW-1:0] tbl_raddr;
  logic [TBL_W-1:0]  tbl_rdata;

  logic              dir_hit;
  logic [SLOT_W-1:0] dir_slot;
  logic [SLOT_W-1:0] sel_slot;
  logic              room;
  logic              ent_ok;
  logic [FRAME_W-1:0] ent_frame;
  logic              wb_dir_we;
  logic              wb_tbl_we;
  logic [TBL_W-1:0]  wb_tbl_wdata;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_dir_present_r <= NEW_DIR_PRESENT_RST;
    end else if (cfg_wr_en) begin
      new_dir_present_r <= cfg_wr_data[0];
    end
  end

  // Advance the clearing sweep over both stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ctr_r <= '0;
    end else if (cmd.clr) begin
      clr_ctr_r <= clr_ctr_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_ctr_r == TBL_AW'(TBL_DEPTH - 1));

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= in_opcode;
      di_r         <= in_virt_addr[DIR_SHIFT +: IDX_W];
      ti_r         <= in_virt_addr[PAGE_SHIFT +: IDX_W];
      off_r        <= in_virt_addr[OFF_W-1:0];
      frame_in_r   <= in_phys_addr[ADDR_W-1 -: FRAME_W];
      present_in_r <= in_entry_flags[0];
    end
  end

  // Directory lookup result, valid in the walk cycle
  assign dir_hit  = dir_rdata[DIR_W-1];
  assign dir_slot = dir_rdata[SLOT_W-1:0];
  assign room     = (next_free_r != NF_W'(TABLE_SLOTS));
  assign sel_slot = dir_hit ? dir_slot : SLOT_W'(next_free_r);

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      hit_r      <= dir_hit;
      alloc_r    <= (op_r == OP_MAP) && !dir_hit && room;
      full_r     <= (op_r == OP_MAP) && !dir_hit && !room;
      slot_r     <= sel_slot;
      tbl_addr_r <= TBL_AW'({sel_slot, ti_r});
    end
  end

  // Table entry, valid in the write-back cycle
  assign ent_ok    = hit_r && tbl_rdata[0];
  assign ent_frame = tbl_rdata[TBL_W-1:1];

  // Write back and form the result
  always_comb begin
    wb_dir_we       = 1'b0;
    wb_tbl_we       = 1'b0;
    wb_tbl_wdata    = '0;
    out_phys_out    = '0;
    out_freed_valid = 1'b0;
    out_freed_frame = '0;
    out_status      = ST_OK;
    case (op_r)
      OP_MAP: begin
        wb_dir_we    = alloc_r;
        wb_tbl_we    = hit_r || alloc_r;
        wb_tbl_wdata = {frame_in_r, present_in_r};
        if (full_r) begin
          out_status = ST_NOSLOT;
        end
      end
      OP_XLATE: begin
        if (ent_ok) begin
          out_phys_out = {ent_frame, off_r};
        end else begin
          out_status = ST_NOMAP;
        end
      end
      OP_UNMAP: begin
        if (ent_ok) begin
          wb_tbl_we       = 1'b1;
          out_freed_valid = 1'b1;
          out_freed_frame = {ent_frame, {OFF_W{1'b0}}};
        end else begin
          out_status = ST_NOMAP;
        end
      end
      default: begin
      end
    endcase
  end

  // Hand out table slots in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= '0;
    end else if (cmd.wb && wb_dir_we) begin
      next_free_r <= next_free_r + 1'b1;
    end
  end

  // Memory port selection: sweep, lookup, write back
  assign dir_raddr = in_virt_addr[DIR_SHIFT +: IDX_W];
  assign dir_we    = cmd.clr || (cmd.wb && wb_dir_we);
  assign dir_waddr = cmd.clr ? clr_ctr_r[DIR_AW-1:0] : di_r;
  assign dir_wdata = cmd.clr ? '0 : {new_dir_present_r, slot_r};

  assign tbl_raddr = TBL_AW'({dir_slot, ti_r});
  assign tbl_we    = cmd.clr || (cmd.wb && wb_tbl_we);
  assign tbl_waddr = cmd.clr ? clr_ctr_r : tbl_addr_r;
  assign tbl_wdata = cmd.clr ? '0 : wb_tbl_wdata;

  tlpte_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpte_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

endmodule

`default_nettype wire

### verif/two_level_page_table_engine_core_tb.sv
`timescale 1ns / 100ps

module two_level_page_table_engine_core_tb;
  import tlpte_pkg::*;

  localparam logic [1:0] OP_NONE  = 2'd3;
  localparam int WATCHDOG_LIMIT   = 60000;
  localparam int ITEMS_PER_PHASE  = 92;
  localparam int NUM_PHASES       = 6;
  localparam int DIR_POOL_N       = 24;
  localparam int TBL_POOL_N       = 8;
  localparam int SETTLE_CYCLES    = 4;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] virt;
    logic [ADDR_W-1:0] phys;
    logic [FLAG_W-1:0] flags;
  } pt_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_out;
    logic              freed_valid;
    logic [ADDR_W-1:0] freed_frame;
    logic [1:0]        status;
  } pt_resp_t;

  // One row of the directed table; fixed rows carry a hand-written answer
  typedef struct {
    logic              set_cfg;
    logic [FLAG_W-1:0] cfg;
    pt_req_t           req;
    logic              fixed;
    pt_resp_t          want;
  } vector_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [ADDR_W-1:0] in_virt_addr;
  logic [ADDR_W-1:0] in_phys_addr;
  logic [FLAG_W-1:0] in_entry_flags;
  logic              cfg_wr_en;
  logic [FLAG_W-1:0] cfg_wr_data;
  logic              out_valid;
  logic [ADDR_W-1:0] out_phys_out;
  logic              out_freed_valid;
  logic [ADDR_W-1:0] out_freed_frame;
  logic [1:0]        out_status;

  // Shadow page directory, table pool and flags register
  logic [FLAG_W-1:0] dir_flags_m [DIR_ENTRIES];
  int unsigned       dir_slot_m [DIR_ENTRIES];
  logic [ADDR_W-1:0] pte_m [TBL_DEPTH];
  int unsigned       slots_taken;
  logic [FLAG_W-1:0] dir_flags_cfg;

  pt_resp_t          pending_results [$];
  vector_t           directed [$];
  logic [IDX_W-1:0]  dir_pool [DIR_POOL_N];
  logic [IDX_W-1:0]  tbl_pool [TBL_POOL_N];
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                burst_left;

  two_level_page_table_engine_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_virt_addr   (in_virt_addr),
    .in_phys_addr   (in_phys_addr),
    .in_entry_flags (in_entry_flags),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_phys_out   (out_phys_out),
    .out_freed_valid(out_freed_valid),
    .out_freed_frame(out_freed_frame),
    .out_status     (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] got,
                               input logic [ADDR_W-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Walk the shadow tables for one request, apply its side effects, return the answer
  function automatic pt_resp_t walk_tables(input pt_req_t r);
    pt_resp_t    res;
    int unsigned di;
    int unsigned ti;
    int unsigned slot;
    int unsigned pos;
    logic        hit;
    res  = '0;
    di   = 32'(r.virt[31:22]);
    ti   = 32'(r.virt[21:12]);
    hit  = dir_flags_m[di][0];
    pos  = dir_slot_m[di] * TBL_ENTRIES + ti;
    case (r.op)
      OP_MAP: begin
        if (hit) begin
          pte_m[pos] = {r.phys[31:12], r.flags};
        end else if (slots_taken >= TABLE_SLOTS) begin
          res.status = ST_NOSLOT;
        end else begin
          slot = slots_taken;
          slots_taken++;
          for (int k = 0; k < TBL_ENTRIES; k++) pte_m[slot * TBL_ENTRIES + k] = '0;
          dir_flags_m[di] = dir_flags_cfg;
          dir_slot_m[di]  = slot;
          pte_m[slot * TBL_ENTRIES + ti] = {r.phys[31:12], r.flags};
        end
      end
      OP_XLATE: begin
        if (hit && pte_m[pos][0]) begin
          res.phys_out = {pte_m[pos][31:12], r.virt[11:0]};
        end else begin
          res.status = ST_NOMAP;
        end
      end
      OP_UNMAP: begin
        if (hit && pte_m[pos][0]) begin
          res.freed_valid = 1'b1;
          res.freed_frame = {pte_m[pos][31:12], 12'h000};
          pte_m[pos]      = '0;
        end else begin
          res.status = ST_NOMAP;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_vec(input logic set_cfg, input logic [FLAG_W-1:0] cfg,
                                  input logic [1:0] op, input logic [ADDR_W-1:0] virt,
                                  input logic [ADDR_W-1:0] phys,
                                  input logic [FLAG_W-1:0] flags, input logic fixed,
                                  input logic [ADDR_W-1:0] w_phys, input logic w_fv,
                                  input logic [ADDR_W-1:0] w_ff, input logic [1:0] w_st);
    vector_t v;
    v.set_cfg = set_cfg;
    v.cfg     = cfg;
    v.req     = '{op: op, virt: virt, phys: phys, flags: flags};
    v.fixed   = fixed;
    v.want    = '{phys_out: w_phys, freed_valid: w_fv, freed_frame: w_ff, status: w_st};
    directed.push_back(v);
  endfunction

  // Mostly addresses from small pools so walks hit; some fully random noise
  function automatic pt_req_t gen_request();
    pt_req_t          r;
    int unsigned      pick;
    logic [OFF_W-1:0] off;
    pick    = $urandom_range(0, 99);
    r.phys  = $urandom;
    r.flags = 12'($urandom);
    off     = 12'($urandom);
    if (pick < 15) begin
      r.op   = 2'($urandom);
      r.virt = $urandom;
    end else begin
      r.virt = {dir_pool[$urandom_range(0, DIR_POOL_N - 1)],
                tbl_pool[$urandom_range(0, TBL_POOL_N - 1)], off};
      if (pick < 50)      r.op = OP_MAP;
      else if (pick < 80) r.op = OP_XLATE;
      else if (pick < 97) r.op = OP_UNMAP;
      else                r.op = OP_NONE;
      if ($urandom_range(0, 99) < 85) r.flags[0] = 1'b1;
    end
    return r;
  endfunction

  // Drive one request in bursts with random gaps, then log its expected answer
  task automatic send_item(input pt_req_t r, input logic fixed, input pt_resp_t want);
    pt_resp_t model;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    start          <= 1'b1;
    in_opcode      <= r.op;
    in_virt_addr   <= r.virt;
    in_phys_addr   <= r.phys;
    in_entry_flags <= r.flags;
    @(posedge clk);
    while (busy) @(posedge clk);
    model = walk_tables(r);
    pending_results.push_back(fixed ? want : model);
  endtask

  // Drain all outstanding results, then write the directory flags register
  task automatic set_dir_flags(input logic [FLAG_W-1:0] v);
    start <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    dir_flags_cfg = v;
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    pt_resp_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, phys_out", out_phys_out, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_phys_out !== want.phys_out)
          flag_mismatch("phys_out", out_phys_out, want.phys_out);
        if (out_freed_valid !== want.freed_valid)
          flag_mismatch("freed_valid", ADDR_W'(out_freed_valid), ADDR_W'(want.freed_valid));
        if (out_freed_frame !== want.freed_frame)
          flag_mismatch("freed_frame", out_freed_frame, want.freed_frame);
        if (out_status !== want.status)
          flag_mismatch("status", ADDR_W'(out_status), ADDR_W'(want.status));
      end
    end
  end

  // Stop on a long stretch with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [FLAG_W-1:0] plan [NUM_PHASES];
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= '0;
    in_virt_addr   <= '0;
    in_phys_addr   <= '0;
    in_entry_flags <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    burst_left    = 0;
    slots_taken   = 0;
    dir_flags_cfg = 12'h007;
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      dir_flags_m[i] = '0;
      dir_slot_m[i]  = 0;
    end
    for (int i = 0; i < TBL_DEPTH; i++) pte_m[i] = '0;

    // Address pools: include both index extremes and the directed directory 5
    dir_pool[0] = '0;
    dir_pool[1] = '1;
    dir_pool[2] = 10'd5;
    for (int i = 3; i < DIR_POOL_N; i++) dir_pool[i] = 10'($urandom);
    tbl_pool[0] = '0;
    tbl_pool[1] = '1;
    tbl_pool[2] = 10'd1;
    for (int i = 3; i < TBL_POOL_N; i++) tbl_pool[i] = 10'($urandom);

    // Present flags first to fill the pool, then no-present to exhaust it, then random and present again
    plan[0] = 12'($urandom) | 12'h001;
    plan[1] = 12'hFFF;
    plan[2] = 12'h000;
    plan[3] = 12'($urandom);
    plan[4] = 12'($urandom) | 12'h001;
    plan[5] = 12'h007;

    // Reset flags: empty walks, unknown opcode, extremes, remap and non-present entries
    add_vec(0, '0, OP_XLATE, 32'h0000_0000, 32'h0, 12'h000, 1, 32'h0, 0, 32'h0, ST_NOMAP);
    add_vec(0, '0, OP_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h000, 1, 32'h0, 0, 32'h0, ST_NOMAP);
    add_vec(0, '0, OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1, 32'h0, 0, 32'h0, ST_OK);
    add_vec(0, '0, OP_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF, 1, 32'h0, 0, 32'h0, ST_OK);
    add_vec(0, '0, OP_XLATE, 32'h0000_0FFF, 32'h0, 12'h000, 1, 32'hFFFF_FFFF, 0, 32'h0, ST_OK);
    add_vec(0, '0, OP_MAP, 32'hFFFF_FFFF, 32'h0000_0000, 12'h001, 1, 32'h0, 0, 32'h0, ST_OK);
    add_vec(0, '0, OP_XLATE, 32'hFFFF_F000, 32'h0, 12'h000, 1, 32'h0, 0, 32'h0, ST_OK);
    add_vec(0, '0, OP_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h000, 1, 32'h0000_0FFF, 0, 32'h0, ST_OK);
    add_vec(0, '0, OP_MAP, 32'h0000_1234, 32'h1234_5678, 12'h000, 1, 32'h0, 0, 32'h0, ST_OK);
    add_vec(0, '0, OP_XLATE, 32'h0000_1234, 32'h0, 12'h000, 1, 32'h0, 0, 32'h0, ST_NOMAP);
    add_vec(0, '0, OP_UNMAP, 32'h0000_1234, 32'h0, 12'h000, 1, 32'h0, 0, 32'h0, ST_NOMAP);
    add_vec(0, '0, OP_MAP, 32'h0000_0000, 32'hABCD_E123, 12'h003, 1, 32'h0, 0, 32'h0, ST_OK);
    add_vec(0, '0, OP_XLATE, 32'h0000_0ABC, 32'h0, 12'h000, 0, '0, 0, '0, ST_OK);
    add_vec(0, '0, OP_UNMAP, 32'h0000_0000, 32'h0, 12'h000, 0, '0, 0, '0, ST_OK);
    add_vec(0, '0, OP_UNMAP, 32'h0000_0000, 32'h0, 12'h000, 1, 32'h0, 0, 32'h0, ST_NOMAP);
    add_vec(0, '0, OP_UNMAP, 32'hFFFF_F000, 32'h0, 12'h000, 0, '0, 0, '0, ST_OK);
    // Directory flags without the present bit: each map takes a fresh slot
    add_vec(1, 12'hFFE, OP_MAP, 32'h0140_0000, 32'h5555_5000, 12'h5A5, 1, 32'h0, 0, 32'h0,
            ST_OK);
    add_vec(0, '0, OP_XLATE, 32'h0140_0000, 32'h0, 12'h000, 1, 32'h0, 0, 32'h0, ST_NOMAP);
    add_vec(0, '0, OP_MAP, 32'h0140_0000, 32'h6666_6000, 12'h001, 1, 32'h0, 0, 32'h0, ST_OK);
    add_vec(0, '0, OP_UNMAP, 32'h0140_0000, 32'h0, 12'h000, 1, 32'h0, 0, 32'h0, ST_NOMAP);
    // All flags set: the directory entry becomes present
    add_vec(1, 12'hFFF, OP_MAP, 32'h0140_0FFF, 32'h8000_0FFF, 12'h001, 0, '0, 0, '0, ST_OK);
    add_vec(0, '0, OP_XLATE, 32'h0140_0FFF, 32'h0, 12'h000, 0, '0, 0, '0, ST_OK);
    add_vec(0, '0, OP_MAP, 32'h0140_1000, 32'h7FFF_F000, 12'h0FF, 0, '0, 0, '0, ST_OK);
    add_vec(0, '0, OP_XLATE, 32'h0140_1123, 32'h0, 12'h000, 0, '0, 0, '0, ST_OK);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed[i]) begin
      if (directed[i].set_cfg) set_dir_flags(directed[i].cfg);
      send_item(directed[i].req, directed[i].fixed, directed[i].want);
    end

    // Random phases, one flags setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_dir_flags(plan[p]);
      repeat (ITEMS_PER_PHASE) send_item(gen_request(), 1'b0, '0);
    end

    // Drain and let the pipeline settle
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
